// ===== rtl/core/smlf_pkg.sv =====
// ----------------------------------------------------------------------------
// smlf_pkg
// Shared types and constants for the LSB-first mode 3 SPI master with FIFOs.
// ----------------------------------------------------------------------------
package smlf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] QUEUE_FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST       = PTR_W'(QUEUE_DEPTH - 1);

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_START = 2'd3;

    // half clock periods per byte, counted down after the load tick
    localparam logic [3:0] HALF_BITS_LOAD = 4'd15;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // classified request
    typedef struct packed {
        logic       tick;
        logic       wr;
        logic       rd;
        logic       start;
        logic [7:0] tx_byte;
        logic       miso;
    } cmd_t;

    // result word, sclk in bit 0
    typedef struct packed {
        logic       rx_empty;
        logic       tx_full;
        logic       tx_accepted;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       mosi;
        logic       sclk;
    } rsp_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/smlf_front.sv =====
// ----------------------------------------------------------------------------
// smlf_front
// Decodes incoming requests and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module smlf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smlf_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            cmd_valid,
    output smlf_pkg::cmd_t                  cmd,
    input  logic                            cmd_pop
);
    import smlf_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       push;

    always_comb
    begin
        dec         = '0;
        dec.tx_byte = s_tdata[7:0];
        dec.miso    = s_tdata[8];
        unique case (s_tuser)
            REQ_TICK:  dec.tick  = 1'b1;
            REQ_WRITE: dec.wr    = 1'b1;
            REQ_READ:  dec.rd    = 1'b1;
            REQ_START: dec.start = 1'b1;
            default:   dec.tick  = 1'b0;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== rtl/core/smlf_back.sv =====
// ----------------------------------------------------------------------------
// smlf_back
// Serial engine, transmit and receive FIFOs, and the result register.
// ----------------------------------------------------------------------------
module smlf_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  smlf_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smlf_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smlf_pkg::*;

    logic [7:0]       tx_mem [QUEUE_DEPTH];
    logic [7:0]       rx_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next, rx_cnt_reg, rx_cnt_next;
    logic [7:0]       out_sh_reg, out_sh_next, in_sh_reg, in_sh_next;
    logic [3:0]       hbc_reg, hbc_next;
    logic             run_reg, run_next;
    logic             clk_lvl_reg, clk_lvl_next;
    logic             dat_lvl_reg, dat_lvl_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             rsp_reg, rsp;

    logic             tx_we, rx_we;
    logic [7:0]       in_sampled;

    assign cmd_pop    = cmd_valid && (!out_valid_reg || m_tready);
    assign in_sampled = {cmd.miso, in_sh_reg[7:1]};

    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_cnt_next  = tx_cnt_reg;
        rx_cnt_next  = rx_cnt_reg;
        out_sh_next  = out_sh_reg;
        in_sh_next   = in_sh_reg;
        hbc_next     = hbc_reg;
        run_next     = run_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        rsp          = '0;

        if (cmd.tick)
        begin
            if (run_reg)
            begin
                if (hbc_reg != 4'd0)
                begin
                    if (hbc_reg[0])
                    begin
                        // rising edge: sample into top of shifter
                        clk_lvl_next = 1'b1;
                        in_sh_next   = in_sampled;
                        if (hbc_reg == 4'd1 && rx_cnt_reg < QUEUE_FULL_CNT)
                        begin
                            rx_we        = 1'b1;
                            rx_tail_next = ptr_inc(rx_tail_reg);
                            rx_cnt_next  = rx_cnt_reg + CNT_W'(1);
                            in_sh_next   = 8'd0;
                        end
                    end
                    else
                    begin
                        // falling edge: drive next bit
                        out_sh_next  = {1'b0, out_sh_reg[7:1]};
                        clk_lvl_next = 1'b0;
                        dat_lvl_next = out_sh_reg[1];
                    end
                    hbc_next = hbc_reg - 4'd1;
                end
                else if (tx_cnt_reg == '0)
                begin
                    run_next     = 1'b0;
                    rsp.done_res = 1'b1;
                end
                else
                begin
                    out_sh_next  = tx_mem[tx_head_reg];
                    tx_head_next = ptr_inc(tx_head_reg);
                    tx_cnt_next  = tx_cnt_reg - CNT_W'(1);
                    in_sh_next   = 8'd0;
                    hbc_next     = HALF_BITS_LOAD;
                    dat_lvl_next = tx_mem[tx_head_reg][0];
                    clk_lvl_next = 1'b0;
                end
            end
        end
        else if (cmd.wr)
        begin
            if (tx_cnt_reg < QUEUE_FULL_CNT)
            begin
                tx_we           = 1'b1;
                tx_tail_next    = ptr_inc(tx_tail_reg);
                tx_cnt_next     = tx_cnt_reg + CNT_W'(1);
                rsp.tx_accepted = 1'b1;
            end
        end
        else if (cmd.rd)
        begin
            if (rx_cnt_reg != '0)
            begin
                rsp.rx_byte  = rx_mem[rx_head_reg];
                rsp.rx_valid = 1'b1;
                rx_head_next = ptr_inc(rx_head_reg);
                rx_cnt_next  = rx_cnt_reg - CNT_W'(1);
            end
        end
        else if (cmd.start)
        begin
            if (tx_cnt_reg != '0)
            begin
                run_next = 1'b1;
            end
        end

        rsp.sclk     = clk_lvl_next;
        rsp.mosi     = dat_lvl_next;
        rsp.busy_res = run_next;
        rsp.tx_full  = (tx_cnt_next >= QUEUE_FULL_CNT);
        rsp.rx_empty = (rx_cnt_next == '0);

        out_valid_next = cmd_pop ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_cnt_reg    <= '0;
            rx_cnt_reg    <= '0;
            out_sh_reg    <= 8'd0;
            in_sh_reg     <= 8'd0;
            hbc_reg       <= 4'd0;
            run_reg       <= 1'b0;
            clk_lvl_reg   <= 1'b1;
            dat_lvl_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop)
            begin
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                tx_cnt_reg  <= tx_cnt_next;
                rx_cnt_reg  <= rx_cnt_next;
                out_sh_reg  <= out_sh_next;
                in_sh_reg   <= in_sh_next;
                hbc_reg     <= hbc_next;
                run_reg     <= run_next;
                clk_lvl_reg <= clk_lvl_next;
                dat_lvl_reg <= dat_lvl_next;
            end
        end
    end

    // storage and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            rsp_reg <= rsp;
            if (tx_we)
            begin
                tx_mem[tx_tail_reg] <= cmd.tx_byte;
            end
            if (rx_we)
            begin
                rx_mem[rx_tail_reg] <= in_sampled;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rsp_reg;

`ifndef SYNTH
    a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_cnt_reg <= QUEUE_FULL_CNT)
        else $error("tx count overflow");

    a_rx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= QUEUE_FULL_CNT)
        else $error("rx count overflow");

    a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (hbc_reg == 4'd0 && clk_lvl_reg))
        else $error("engine stopped mid byte");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_reg.done_res) |-> !rsp_reg.busy_res)
        else $error("done reported while busy");
`endif

endmodule

// ===== rtl/core/spi_master_lsb_first_fifo_unit.sv =====
// A request word passes the command queue register, then the result register,
//   before its result word leaves.
// Throughput: one request word per cycle; the engine and FIFO update for a
//   word is computed combinationally, so the rate is set by output acceptance.
// Reset (rst_n low, asynchronous): FIFOs empty, engine stopped, sclk and mosi
//   high, shifters cleared; FIFO storage is not cleared.
// ----------------------------------------------------------------------------
// spi_master_lsb_first_fifo_unit
// Tick-driven SPI master, mode 3, LSB first, with 16-byte transmit and
// receive FIFOs. Front decodes and queues requests, back runs the engine.
// ----------------------------------------------------------------------------
module spi_master_lsb_first_fifo_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] tx_byte, [8] miso, [15:9] zero
    input  logic [smlf_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type: 0 tick, 1 write tx byte, 2 read rx byte, 3 start
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] sclk, [1] mosi, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] rx_valid, [13] tx_accepted, [14] tx_full, [15] rx_empty
    output logic [smlf_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smlf_pkg::*;

    // decoded request handed from front to back
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Front: classifies req_type and buffers two words so the input side
    // keeps flowing while the result register waits on m_tready.
    smlf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: one request per cycle whenever the result register is free or
    // being drained. While running, ticks step the half-period counter: load
    // on zero or stop if tx is empty; sample miso on odd, shift out on even counts.
    smlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
